// ===== hdl/rhsv_pkg.sv =====
// Package for the RGB to HSV pixel converter: shared constants, the sector
// code and the work item passed from the front end to the divider pipeline.
// No dependencies.
package rhsv_pkg;

  localparam int unsigned ChanW = 8;
  localparam int unsigned HueW = 15;
  localparam int unsigned HueQW = 12;  // quotient bits of the hue division
  localparam int unsigned SatQW = 8;   // quotient bits of the saturation division
  localparam int unsigned NumStages = 6;  // divider stages, two quotient bits each
  localparam int unsigned SatStages = 4;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw = $clog2(FifoDepth);

  localparam logic [HueW-1:0] HueRedOff = 15'd0;
  localparam logic [HueW-1:0] HueGreenOff = 15'd7680;
  localparam logic [HueW-1:0] HueBlueOff = 15'd15360;
  localparam logic [HueW-1:0] HueFull = 15'd23040;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } rhsv_sector_e;

  typedef struct packed {
    rhsv_sector_e     sector;
    logic             neg;    // hue difference term is negative
    logic [ChanW-1:0] mag;    // magnitude of the hue difference term
    logic [ChanW-1:0] delta;  // max - min
    logic [ChanW-1:0] maxc;   // largest channel
  } rhsv_work_t;

endpackage

// ===== hdl/rhsv_front.sv =====
// Front end of the RGB to HSV converter: accepts pixels, finds max, min,
// sector and hue difference term, and hands a work item to the queue.
// Depends on rhsv_pkg.
module rhsv_front import rhsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ChanW-1:0] red_i,
  input  logic [ChanW-1:0] green_i,
  input  logic [ChanW-1:0] blue_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rhsv_work_t       out_work_o
);

  logic       vld_q, vld_d;
  rhsv_work_t work_q, work_d;
  logic       load;
  logic [ChanW-1:0] minc;
  logic [ChanW:0]   diff;  // two's complement difference, one extra bit

  assign in_ready_o = !vld_q || out_ready_i;
  assign load = in_valid_i && in_ready_o;

  // Ties go to red first, then green.
  always_comb begin
    work_d = '0;
    if (red_i >= green_i && red_i >= blue_i) begin
      work_d.sector = SEC_RED;
      work_d.maxc = red_i;
      diff = {1'b0, green_i} - {1'b0, blue_i};
    end else if (green_i >= blue_i) begin
      work_d.sector = SEC_GREEN;
      work_d.maxc = green_i;
      diff = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      work_d.sector = SEC_BLUE;
      work_d.maxc = blue_i;
      diff = {1'b0, red_i} - {1'b0, green_i};
    end
    minc = red_i;
    if (green_i < minc) minc = green_i;
    if (blue_i < minc) minc = blue_i;
    work_d.delta = work_d.maxc - minc;
    work_d.neg = diff[ChanW];
    work_d.mag = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];
  end

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      work_q <= work_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_work_o = work_q;

endmodule

// ===== hdl/rhsv_fifo.sv =====
// Short queue of work items between the front end and the divider pipeline.
// Depends on rhsv_pkg.
module rhsv_fifo import rhsv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  rhsv_work_t push_work_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output rhsv_work_t pop_work_o
);

  rhsv_work_t        mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoAw:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != (FifoAw+1)'(FifoDepth));
  assign pop_valid_o = (count_q != '0);
  assign push = push_valid_i && push_ready_o;
  assign pop = pop_valid_o && pop_ready_i;
  assign pop_work_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_work_i;
    end
  end

endmodule

// ===== hdl/rhsv_back.sv =====
// Back end of the RGB to HSV converter: pipelined restoring dividers for hue
// and saturation, the hue offset and wrap, and the output register.
// Depends on rhsv_pkg.
module rhsv_back import rhsv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rhsv_work_t       in_work_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [HueW-1:0]  hue_o,
  output logic [ChanW-1:0] sat_o,
  output logic [ChanW-1:0] bri_o
);

  // One restoring step: shift in a numerator bit, subtract when it fits.
  // Returns {quotient bit, new remainder}.
  function automatic logic [ChanW:0] div_step(input logic [ChanW-1:0] rem,
                                              input logic nbit,
                                              input logic [ChanW-1:0] den);
    logic [ChanW:0] t;
    logic [ChanW:0] s;
    t = {rem, nbit};
    s = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {1'b1, s[ChanW-1:0]};
    end
    return {1'b0, t[ChanW-1:0]};
  endfunction

  logic en;

  // Stage registers.
  logic             vld_q [NumStages];
  rhsv_work_t       wk_q  [NumStages];
  logic [ChanW-1:0] hr_q  [NumStages];
  logic [HueQW-1:0] hq_q  [NumStages];
  logic [HueQW-1:0] hn_q  [NumStages];
  logic [ChanW-1:0] sr_q  [NumStages];
  logic [SatQW-1:0] sq_q  [NumStages];
  logic [SatQW-1:0] sn_q  [NumStages];

  // Stage inputs and next values.
  logic             vld_in [NumStages];
  rhsv_work_t       wk_in  [NumStages];
  logic [ChanW-1:0] hr_in  [NumStages];
  logic [HueQW-1:0] hq_in  [NumStages];
  logic [HueQW-1:0] hn_in  [NumStages];
  logic [ChanW-1:0] sr_in  [NumStages];
  logic [SatQW-1:0] sq_in  [NumStages];
  logic [SatQW-1:0] sn_in  [NumStages];
  logic [ChanW-1:0] hr_d   [NumStages];
  logic [HueQW-1:0] hq_d   [NumStages];
  logic [ChanW-1:0] sr_d   [NumStages];
  logic [SatQW-1:0] sq_d   [NumStages];

  logic [HueQW+ChanW-1:0] hue_num;  // 3840 * mag
  logic [SatQW+ChanW-1:0] sat_num;  // 255 * delta

  logic             out_vld_q;
  logic [HueW-1:0]  hue_q, hue_d;
  logic [ChanW-1:0] sat_q, sat_d;
  logic [ChanW-1:0] bri_q;

  assign en = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  assign hue_num = {in_work_i.mag, 12'd0} - {4'd0, in_work_i.mag, 8'd0};
  assign sat_num = {in_work_i.delta, 8'd0} - {8'd0, in_work_i.delta};

  always_comb begin
    // The upper numerator bits are already below the divisor.
    vld_in[0] = in_valid_i;
    wk_in[0] = in_work_i;
    hr_in[0] = hue_num[HueQW+ChanW-1:HueQW];
    hq_in[0] = '0;
    hn_in[0] = hue_num[HueQW-1:0];
    sr_in[0] = sat_num[SatQW+ChanW-1:SatQW];
    sq_in[0] = '0;
    sn_in[0] = sat_num[SatQW-1:0];
    for (int k = 1; k < NumStages; k++) begin
      vld_in[k] = vld_q[k-1];
      wk_in[k] = wk_q[k-1];
      hr_in[k] = hr_q[k-1];
      hq_in[k] = hq_q[k-1];
      hn_in[k] = hn_q[k-1];
      sr_in[k] = sr_q[k-1];
      sq_in[k] = sq_q[k-1];
      sn_in[k] = sn_q[k-1];
    end
  end

  always_comb begin
    logic [ChanW:0] st;
    for (int k = 0; k < NumStages; k++) begin
      hr_d[k] = hr_in[k];
      hq_d[k] = hq_in[k];
      sr_d[k] = sr_in[k];
      sq_d[k] = sq_in[k];
      for (int j = 0; j < 2; j++) begin
        st = div_step(hr_d[k], hn_in[k][HueQW-1-2*k-j], wk_in[k].delta);
        hr_d[k] = st[ChanW-1:0];
        hq_d[k] = {hq_d[k][HueQW-2:0], st[ChanW]};
      end
    end
    // Saturation needs fewer quotient bits; the later stages only carry it.
    for (int k = 0; k < SatStages; k++) begin
      for (int j = 0; j < 2; j++) begin
        st = div_step(sr_d[k], sn_in[k][SatQW-1-2*k-j], wk_in[k].maxc);
        sr_d[k] = st[ChanW-1:0];
        sq_d[k] = {sq_d[k][SatQW-2:0], st[ChanW]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumStages; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NumStages; k++) begin
        vld_q[k] <= vld_in[k];
      end
      out_vld_q <= vld_q[NumStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NumStages; k++) begin
        wk_q[k] <= wk_in[k];
        hr_q[k] <= hr_d[k];
        hq_q[k] <= hq_d[k];
        hn_q[k] <= hn_in[k];
        sr_q[k] <= sr_d[k];
        sq_q[k] <= sq_d[k];
        sn_q[k] <= sn_in[k];
      end
      hue_q <= hue_d;
      sat_q <= sat_d;
      bri_q <= wk_q[NumStages-1].maxc;
    end
  end

  // Final hue: negative terms round toward minus infinity, so the quotient
  // magnitude rounds up; a negative sum wraps by a full circle.
  always_comb begin
    rhsv_work_t       wl;
    logic [HueW-1:0]  off;
    logic [HueQW:0]   qc;
    logic signed [HueW+1:0] hs;
    wl = wk_q[NumStages-1];
    qc = {1'b0, hq_q[NumStages-1]} +
         (HueQW+1)'(wl.neg && (hr_q[NumStages-1] != '0));
    case (wl.sector)
      SEC_RED:   off = HueRedOff;
      SEC_GREEN: off = HueGreenOff;
      SEC_BLUE:  off = HueBlueOff;
      default:   off = HueRedOff;
    endcase
    if (wl.neg) begin
      hs = $signed({2'b00, off}) - $signed({4'b0000, qc});
    end else begin
      hs = $signed({2'b00, off}) + $signed({4'b0000, qc});
    end
    if (hs < 0) begin
      hs = hs + $signed({2'b00, HueFull});
    end
    hue_d = hs[HueW-1:0];
    sat_d = sq_q[NumStages-1];
    // Gray and black pixels have no hue and no saturation.
    if (wl.delta == '0) begin
      hue_d = '0;
      sat_d = '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign hue_o = hue_q;
  assign sat_o = sat_q;
  assign bri_o = bri_q;

endmodule

// ===== hdl/rgb_to_hsv_pixel.sv =====
// Top level of the RGB to HSV pixel converter.
// Depends on rhsv_pkg, rhsv_front, rhsv_fifo and rhsv_back.
//
// Converts one 8-bit RGB pixel per request into hue, saturation and value.
// Value (brightness) is the largest channel. Saturation is
// floor(255 * (max - min) / max), zero for black or gray pixels. Hue is in
// units of 1/64 degree (0 to 23039); the sector is chosen with red winning
// ties over green and green over blue, the difference term is scaled by
// 3840 / (max - min) with rounding toward minus infinity, the sector offset
// (0, 7680 or 15360) is added and a negative hue wraps by 23040. Gray pixels
// give a hue of zero. The block keeps no state between pixels. With no
// back-pressure it sustains one pixel per clock: the front end registers the
// classified pixel, a four-entry queue decouples it from the back end, and
// the back end runs a six-stage restoring divider for hue beside a
// four-stage one for saturation, each producing two quotient bits per stage,
// followed by an output register. While a result waits at the output the
// whole back end pipeline holds still, so the input is blocked once the
// queue and the front end register are full.
module rgb_to_hsv_pixel import rhsv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // red [7:0], green [15:8], blue [23:16]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // hue [14:0], saturation [22:15],
                                        // brightness [30:23], zero [31]
);

  logic             fr_valid, fr_ready;
  rhsv_work_t       fr_work;
  logic             bk_valid, bk_ready;
  rhsv_work_t       bk_work;
  logic [HueW-1:0]  hue;
  logic [ChanW-1:0] sat;
  logic [ChanW-1:0] bri;

  rhsv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .red_i       (s_axis_tdata_i[7:0]),
    .green_i     (s_axis_tdata_i[15:8]),
    .blue_i      (s_axis_tdata_i[23:16]),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_work_o  (fr_work)
  );

  rhsv_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_work_i  (fr_work),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_work_o   (bk_work)
  );

  rhsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .in_work_i   (bk_work),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .hue_o       (hue),
    .sat_o       (sat),
    .bri_o       (bri)
  );

  // The top bit is padding to a whole byte.
  assign m_axis_tdata_o = {1'b0, bri, sat, hue};

endmodule

// ===== hdl/rhsv_checker.sv =====
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rgb_to_hsv_pixel.
module rhsv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  // A result held under back-pressure must not change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Hue stays below a full circle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[14:0] < 15'd23040)
    else $error("hue out of range");

  // Zero saturation means a gray pixel, which has no hue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[22:15] == 8'd0 |-> m_axis_tdata_o[14:0] == 15'd0)
    else $error("gray pixel with nonzero hue");

  // A black pixel has no saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[30:23] == 8'd0 |-> m_axis_tdata_o[22:15] == 8'd0)
    else $error("black pixel with nonzero saturation");

endmodule

bind rgb_to_hsv_pixel rhsv_checker u_rhsv_checker (.*);
